FILE: hdl/mksg_pkg.sv
// Package for the Morse keying segment generator.
// Holds the sequencer state type, the segment length codes and the letter table.
// No dependencies.
package mksg_pkg;

    localparam int CHAR_W  = 8;
    localparam int DOT_W   = 10;
    localparam int DUR_W   = 13;
    localparam int PAT_W   = 4;
    localparam int LEN_W   = 3;
    localparam int IDX_W   = 5;

    localparam logic [DOT_W-1:0]  DOT_LEN_RESET = 10'd120;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_A        = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z        = 8'h5A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PULSE_ON,
        ST_PULSE_OFF,
        ST_BODY,
        ST_KEY_ON,
        ST_KEY_OFF
    } t_state;

    // segment length in dot units
    typedef enum logic [1:0] {
        U_ZERO,
        U_ONE,
        U_THREE,
        U_SEVEN
    } t_units;

    typedef enum logic [1:0] {
        K_LETTER,
        K_SPACE,
        K_BAD
    } t_kind;

    // pat: first element at the MSB, 1 = dash
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } t_morse;

    function automatic t_morse morse_lookup(input logic [IDX_W-1:0] idx);
        t_morse m;
        unique case (idx)
            5'd0:    m = '{len: 3'd2, pat: 4'b0100};  // A
            5'd1:    m = '{len: 3'd4, pat: 4'b1000};  // B
            5'd2:    m = '{len: 3'd4, pat: 4'b1010};  // C
            5'd3:    m = '{len: 3'd3, pat: 4'b1000};  // D
            5'd4:    m = '{len: 3'd1, pat: 4'b0000};  // E
            5'd5:    m = '{len: 3'd4, pat: 4'b0010};  // F
            5'd6:    m = '{len: 3'd3, pat: 4'b1100};  // G
            5'd7:    m = '{len: 3'd4, pat: 4'b0000};  // H
            5'd8:    m = '{len: 3'd2, pat: 4'b0000};  // I
            5'd9:    m = '{len: 3'd4, pat: 4'b0111};  // J
            5'd10:   m = '{len: 3'd3, pat: 4'b1010};  // K
            5'd11:   m = '{len: 3'd4, pat: 4'b0100};  // L
            5'd12:   m = '{len: 3'd2, pat: 4'b1100};  // M
            5'd13:   m = '{len: 3'd2, pat: 4'b1000};  // N
            5'd14:   m = '{len: 3'd3, pat: 4'b1110};  // O
            5'd15:   m = '{len: 3'd4, pat: 4'b0110};  // P
            5'd16:   m = '{len: 3'd4, pat: 4'b1101};  // Q
            5'd17:   m = '{len: 3'd3, pat: 4'b0100};  // R
            5'd18:   m = '{len: 3'd3, pat: 4'b0000};  // S
            5'd19:   m = '{len: 3'd1, pat: 4'b1000};  // T
            5'd20:   m = '{len: 3'd3, pat: 4'b0010};  // U
            5'd21:   m = '{len: 3'd4, pat: 4'b0001};  // V
            5'd22:   m = '{len: 3'd3, pat: 4'b0110};  // W
            5'd23:   m = '{len: 3'd4, pat: 4'b1001};  // X
            5'd24:   m = '{len: 3'd4, pat: 4'b1011};  // Y
            5'd25:   m = '{len: 3'd4, pat: 4'b1100};  // Z
            default: m = '{len: 3'd1, pat: 4'b0000};
        endcase
        return m;
    endfunction

endpackage

FILE: hdl/morse_keying_segment_generator.sv
// Morse keying segment generator: sequencer, letter decode and duration unit.
// Depends on mksg_pkg.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one character and a start flag.
//   Output channel (o_valid / i_ready) gives one segment word per handshake:
//   relay level, marker level, duration in ms, bad-char flag and last flag.
//   i_cfg_we / i_cfg_data load the dot length (ms); write it only while idle.
//   A word is taken only in the idle state. After the accepting edge the
//   sequencer leaves idle and loads the first segment into the output
//   register once that register is empty or i_ready is high. One segment
//   is produced per cycle while the receiver keeps up (at most ten per item).
//   Each segment's duration comes from one shared add/subtract unit that
//   forms 0, 1, 3 or 7 times the dot length by shift-and-add or subtract.
//   When i_ready is low the output register holds its word and the
//   sequencer waits; nothing is dropped. The input side reopens as soon as
//   the last segment is loaded, even if that segment is still waiting.
//   Reset (i_rst_n low, synchronous) empties the output, returns to idle
//   and sets the dot length to 120 ms.
module morse_keying_segment_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [mksg_pkg::CHAR_W-1:0] i_character,
    input  logic                       i_message_start,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_relay_on,
    output logic                       o_marker_on,
    output logic [mksg_pkg::DUR_W-1:0] o_duration_ms,
    output logic                       o_bad_char,
    output logic                       o_last,
    input  logic                       i_cfg_we,
    input  logic [mksg_pkg::DOT_W-1:0] i_cfg_data
);
    import mksg_pkg::*;

    t_state               r_state, n_state;
    t_kind                r_kind;
    logic [PAT_W-1:0]     r_pat;
    logic [LEN_W-1:0]     r_left;
    logic [DOT_W-1:0]     r_dot;

    logic                 r_o_valid;
    logic                 r_relay, r_marker, r_bad, r_last;
    logic [DUR_W-1:0]     r_dur;

    logic                 accept;
    logic                 emit;
    t_kind                in_kind;
    t_morse               in_morse;
    logic [IDX_W-1:0]     in_idx;

    // segment being built
    logic                 seg_relay, seg_marker, seg_bad, seg_last;
    t_units               seg_units;

    // shared duration unit
    logic [DUR_W-1:0]     op_a, op_b, dot_ext, dur;
    logic                 op_sub;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign emit    = (r_state != ST_IDLE) && (!r_o_valid || i_ready);

    assign in_idx   = IDX_W'(i_character - CHAR_A);
    assign in_morse = morse_lookup(in_idx);

    always_comb begin
        priority if (i_character == CHAR_SPACE) begin
            in_kind = K_SPACE;
        end else if (i_character >= CHAR_A && i_character <= CHAR_Z) begin
            in_kind = K_LETTER;
        end else begin
            in_kind = K_BAD;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_message_start) begin
                        n_state = ST_PULSE_ON;
                    end else if (in_kind == K_LETTER) begin
                        n_state = ST_KEY_ON;
                    end else begin
                        n_state = ST_BODY;
                    end
                end
            end
            ST_PULSE_ON: begin
                if (emit) begin
                    n_state = ST_PULSE_OFF;
                end
            end
            ST_PULSE_OFF: begin
                if (emit) begin
                    n_state = (r_kind == K_LETTER) ? ST_KEY_ON : ST_BODY;
                end
            end
            ST_BODY: begin
                if (emit) begin
                    n_state = ST_IDLE;
                end
            end
            ST_KEY_ON: begin
                if (emit) begin
                    n_state = ST_KEY_OFF;
                end
            end
            ST_KEY_OFF: begin
                if (emit) begin
                    n_state = (r_left == LEN_W'(1)) ? ST_IDLE : ST_KEY_ON;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // segment fields per state
    always_comb begin
        seg_relay  = 1'b0;
        seg_marker = 1'b0;
        seg_bad    = 1'b0;
        seg_last   = 1'b0;
        seg_units  = U_ZERO;
        unique case (r_state)
            ST_PULSE_ON: begin
                seg_relay  = 1'b1;
                seg_marker = 1'b1;
                seg_units  = U_SEVEN;
            end
            ST_PULSE_OFF: begin
                seg_units = U_SEVEN;
            end
            ST_BODY: begin
                seg_last = 1'b1;
                if (r_kind == K_SPACE) begin
                    seg_marker = 1'b1;
                    seg_units  = U_SEVEN;
                end else begin
                    seg_bad = 1'b1;
                end
            end
            ST_KEY_ON: begin
                seg_relay = 1'b1;
                seg_units = r_pat[PAT_W-1] ? U_THREE : U_ONE;
            end
            ST_KEY_OFF: begin
                seg_units = U_ONE;
                seg_last  = (r_left == LEN_W'(1));
            end
            default: begin
                seg_units = U_ZERO;
            end
        endcase
    end

    // units times dot length: d, 2d + d, 8d - d
    assign dot_ext = DUR_W'(r_dot);
    always_comb begin
        op_sub = 1'b0;
        unique case (seg_units)
            U_ZERO: begin
                op_a = '0;
                op_b = '0;
            end
            U_ONE: begin
                op_a = dot_ext;
                op_b = '0;
            end
            U_THREE: begin
                op_a = dot_ext << 1;
                op_b = dot_ext;
            end
            U_SEVEN: begin
                op_a   = dot_ext << 3;
                op_b   = dot_ext;
                op_sub = 1'b1;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end
    assign dur = op_sub ? (op_a - op_b) : (op_a + op_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_dot     <= DOT_LEN_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_dot <= i_cfg_data;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= in_kind;
            r_pat  <= in_morse.pat;
            r_left <= in_morse.len;
        end else if (emit && r_state == ST_KEY_OFF) begin
            r_pat  <= r_pat << 1;
            r_left <= r_left - LEN_W'(1);
        end
        if (emit) begin
            r_relay  <= seg_relay;
            r_marker <= seg_marker;
            r_bad    <= seg_bad;
            r_last   <= seg_last;
            r_dur    <= dur;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_relay_on    = r_relay;
    assign o_marker_on   = r_marker;
    assign o_duration_ms = r_dur;
    assign o_bad_char    = r_bad;
    assign o_last        = r_last;

endmodule
